@@ rtl/pl_pkg.sv @@
`timescale 1ns / 1ps

package pl_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = 5;
    localparam int POS_W      = 5;
    localparam int ELEM_W     = 32;

    localparam logic [2:0] MD_INS_POS   = 3'd0;
    localparam logic [2:0] MD_INS_FRONT = 3'd1;
    localparam logic [2:0] MD_INS_BACK  = 3'd2;
    localparam logic [2:0] MD_DEL_POS   = 3'd3;
    localparam logic [2:0] MD_DEL_FRONT = 3'd4;
    localparam logic [2:0] MD_DEL_BACK  = 3'd5;
    localparam logic [2:0] MD_DUMP      = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
        logic [ELEM_W-1:0] element;
        logic              element_valid;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_WR,
        S_PUT,
        S_DEL_CHK,
        S_DEL_WR,
        S_DMP_RD,
        S_DMP_OUT
    } t_state;

endpackage

@@ rtl/pl_ram.sv @@
`timescale 1ns / 1ps

module pl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/positional_list_engine.sv @@
`timescale 1ns / 1ps

// Insert moves the slots from the end down to the target, then writes the new word;
// delete moves the later slots up by one; errors and no-ops give a single status result.
// One item at a time, taken only when idle with no result pending. Dump streams each element
// by a RAM read, then an output load, waiting on the sink; an empty dump is a status result.
// Reset (i_rst_n low, synchronous): count, sequencer and output valid cleared; slot RAM kept.
module positional_list_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pl_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pl_pkg::t_out_item o_out_data
);

    import pl_pkg::*;

    // ------------------------------------------------------------------
    // State
    //   r_state  : sequencer
    //   r_idx    : walking slot index of the shift / dump
    //   r_tgt    : slot where the new word lands on insert
    //   r_word   : word to insert
    //   r_status : status reported once the operation ends
    //   r_resp   : a single-beat result is pending in the sequencer
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_tgt, n_tgt;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic [1:0]           r_status, n_status;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_resp, n_resp;

    // Output register: parts the result side from the input side.
    t_out_item            r_out, n_out;
    logic                 r_ov, n_ov;

    // RAM port controls
    logic                  w_we, w_re;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata, w_rdata;

    logic                  w_out_free;
    logic                  w_accept;
    logic [CNT_W:0]        w_pos6, w_cnt6;
    logic [CNT_W:0]        w_next6;

    pl_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_ov || i_out_ready;
    // New item only when the sequencer is free and no single-beat result waits.
    assign o_in_ready = (r_state == S_IDLE) && !r_resp;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_pos6  = {1'b0, i_in_data.position};
    assign w_cnt6  = {1'b0, r_count};
    // shared incrementer for the walking index (delete/dump end test)
    assign w_next6 = (CNT_W+1)'(r_idx) + (CNT_W+1)'(1);

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_tgt    = r_tgt;
        n_word   = r_word;
        n_status = r_status;
        n_count  = r_count;
        n_resp   = r_resp;
        n_out    = r_out;
        n_ov     = r_ov && !i_out_ready;

        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = r_idx;

        // Pending single-beat result: status plus count, no element.
        if (r_resp && w_out_free) begin
            n_out.status        = r_status;
            n_out.count         = r_count;
            n_out.element       = '0;
            n_out.element_valid = 1'b0;
            n_out.last          = 1'b1;
            n_ov                = 1'b1;
            n_resp              = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_word   = DATA_WIDTH'(i_in_data.value);
                    n_status = ST_OK;
                    unique case (i_in_data.mode) inside
                        MD_INS_POS, MD_INS_FRONT, MD_INS_BACK: begin
                            if (i_in_data.mode == MD_INS_POS &&
                                (i_in_data.position == '0 || w_pos6 > w_cnt6 + 1'b1)) begin
                                n_status = ST_BADPOS;
                                n_resp   = 1'b1;
                            end else if (w_cnt6 >= (CNT_W+1)'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_resp   = 1'b1;
                            end else begin
                                if (i_in_data.mode == MD_INS_POS) begin
                                    n_tgt = IDX_W'(i_in_data.position - 1'b1);
                                end else if (i_in_data.mode == MD_INS_FRONT) begin
                                    n_tgt = '0;
                                end else begin
                                    n_tgt = r_count[IDX_W-1:0];
                                end
                                n_idx   = r_count[IDX_W-1:0];
                                n_state = S_INS_CHK;
                            end
                        end
                        MD_DEL_POS, MD_DEL_FRONT, MD_DEL_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_resp   = 1'b1;
                            end else if (i_in_data.mode == MD_DEL_POS &&
                                         (i_in_data.position == '0 || w_pos6 > w_cnt6)) begin
                                n_status = ST_BADPOS;
                                n_resp   = 1'b1;
                            end else begin
                                if (i_in_data.mode == MD_DEL_POS) begin
                                    n_idx = IDX_W'(i_in_data.position - 1'b1);
                                end else if (i_in_data.mode == MD_DEL_FRONT) begin
                                    n_idx = '0;
                                end else begin
                                    n_idx = IDX_W'(r_count - 1'b1);
                                end
                                n_state = S_DEL_CHK;
                            end
                        end
                        MD_DUMP: begin
                            if (r_count == '0) begin
                                n_resp = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DMP_RD;
                            end
                        end
                        default: begin
                            n_resp = 1'b1;
                        end
                    endcase
                end
            end

            // Open the gap: slot[i] <= slot[i-1] walking down to the target.
            S_INS_CHK: begin
                if (r_idx == r_tgt) begin
                    n_state = S_PUT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx - 1'b1;
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                n_idx   = r_idx - 1'b1;
                n_state = S_INS_CHK;
            end

            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_tgt;
                w_wdata = r_word;
                n_count = r_count + 1'b1;
                n_resp  = 1'b1;
                n_state = S_IDLE;
            end

            // Close the gap: slot[i] <= slot[i+1] while i+1 < count.
            S_DEL_CHK: begin
                if (w_next6 >= w_cnt6) begin
                    n_count = r_count - 1'b1;
                    n_resp  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + 1'b1;
                    n_state = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                n_idx   = r_idx + 1'b1;
                n_state = S_DEL_CHK;
            end

            S_DMP_RD: begin
                w_re    = 1'b1;
                w_raddr = r_idx;
                n_state = S_DMP_OUT;
            end

            // Read data holds until the next read, so waiting on the sink is safe.
            S_DMP_OUT: begin
                if (w_out_free) begin
                    n_out.status        = ST_OK;
                    n_out.count         = r_count;
                    n_out.element       = ELEM_W'(w_rdata);
                    n_out.element_valid = 1'b1;
                    n_out.last          = (w_next6 == w_cnt6);
                    n_ov                = 1'b1;
                    if (w_next6 == w_cnt6) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DMP_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_resp  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_resp  <= n_resp;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_word   <= n_word;
        r_status <= n_status;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt6 <= (CNT_W+1)'(CAPACITY))
        else $error("element count above capacity");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |->
            (r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1))
        else $error("count moved by more than one");

    a_idle_no_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_we)
        else $error("slot write while idle");

    a_dump_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.element_valid |-> r_out.status == ST_OK && r_out.count != '0)
        else $error("dump element with bad status or empty count");
`endif

endmodule
